@@ rtl/core/hex_run_length_frame_decoder_macros.svh @@
// Assertion macros for the hex run-length frame decoder.
// Used by the top level only; needs nothing else.
`ifndef HEX_RUN_LENGTH_FRAME_DECODER_MACROS_SVH
`define HEX_RUN_LENGTH_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HRLFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrlfd: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define HRLFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrlfd: next-cycle check failed");

`endif

@@ rtl/core/hrlfd_pkg.sv @@
// Shared types and constants of the hex run-length frame decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package hrlfd_pkg;

   localparam int unsigned FRAME_WIDTH_DEF  = 80;
   localparam int unsigned FRAME_HEIGHT_DEF = 25;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned NIB_W  = 4;
   localparam int unsigned COL_W  = 7;
   localparam int unsigned ROW_W  = 5;
   localparam int unsigned LEN_W  = 7;
   localparam int unsigned FP_W   = 11;  // stored frame position
   localparam int unsigned POS_W  = 12;  // largest sum: 1999 + 127
   localparam int unsigned CALC_W = 13;  // holds the largest frame size
   localparam int unsigned RECIP_SHIFT = 24;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

   typedef struct packed {
      logic             color;
      logic [LEN_W-1:0] len;
   } run_type;

   typedef struct packed {
      logic             pixel_color;
      logic [COL_W-1:0] start_column;
      logic [ROW_W-1:0] start_row;
      logic [LEN_W-1:0] run_length;
      logic             end_of_frame;
      logic             last_segment;
   } seg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic {
      BK_IDLE,
      BK_SECOND
   } back_state_type;

endpackage

`default_nettype wire

@@ rtl/core/hrlfd_queue.sv @@
// Small first-word-fall-through queue of flip-flops.
// Depends on hrlfd_pkg for the status struct.
`default_nettype none

module hrlfd_queue #(
   parameter int unsigned DEPTH = hrlfd_pkg::QUEUE_DEPTH,
   parameter int unsigned WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [WIDTH-1:0]      push_data,
   input  wire logic                  pop,
   output      logic [WIDTH-1:0]      pop_data,
   output      hrlfd_pkg::q_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/hrlfd_front.sv @@
// Front end: drops blanks, pairs hex digits into run bytes, queues nonzero runs.
// Depends on hrlfd_pkg for character codes and the run struct.
`default_nettype none

module hrlfd_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [hrlfd_pkg::CHAR_W-1:0]  char_in,
   output      logic                          run_push,
   output      hrlfd_pkg::run_type            run
);

   logic                         wait_ff, wait_in;
   logic [hrlfd_pkg::NIB_W-1:0]  high_ff, high_in;
   logic [hrlfd_pkg::NIB_W-1:0]  nib;
   logic                         skip;
   logic [hrlfd_pkg::CHAR_W-1:0] byte_val;

   // Only '0'..'9' and uppercase 'A'..'F' are digits; anything else reads as zero.
   always_comb begin
      nib = '0;
      if (char_in inside {[8'h30:8'h39]}) begin
         nib = char_in[hrlfd_pkg::NIB_W-1:0];
      end else if (char_in inside {[8'h41:8'h46]}) begin
         nib = char_in[hrlfd_pkg::NIB_W-1:0] + 4'd9;
      end
   end

   assign skip = char_in inside {hrlfd_pkg::CHAR_SPACE, hrlfd_pkg::CHAR_CR, hrlfd_pkg::CHAR_LF};
   assign byte_val  = {high_ff, nib};
   assign run.color = byte_val[hrlfd_pkg::CHAR_W-1];
   assign run.len   = byte_val[hrlfd_pkg::LEN_W-1:0];
   // Drop zero-length runs here so the back end never sees them.
   assign run_push  = accept && !skip && wait_ff && (run.len != '0);

   always_comb begin
      wait_in = wait_ff;
      high_in = high_ff;
      if (accept && !skip) begin
         wait_in = !wait_ff;
         if (!wait_ff) begin
            high_in = nib;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff <= 1'b0;
         high_ff <= '0;
      end else begin
         wait_ff <= wait_in;
         high_ff <= high_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/hrlfd_back.sv @@
// Back end: places runs on the frame, splits at the frame end, tracks column and row.
// Depends on hrlfd_pkg for widths, structs and the state enum.
`default_nettype none

module hrlfd_back #(
   parameter int unsigned FRAME_WIDTH  = hrlfd_pkg::FRAME_WIDTH_DEF,
   parameter int unsigned FRAME_HEIGHT = hrlfd_pkg::FRAME_HEIGHT_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire hrlfd_pkg::q_status_type run_status,
   input  wire hrlfd_pkg::run_type      run,
   output      logic                    run_pop,
   input  wire hrlfd_pkg::q_status_type seg_status,
   output      logic                    seg_push,
   output      hrlfd_pkg::seg_type      seg
);

   localparam int unsigned CALC_W = hrlfd_pkg::CALC_W;
   localparam int unsigned POS_W  = hrlfd_pkg::POS_W;
   localparam int unsigned COL_W  = hrlfd_pkg::COL_W;
   localparam int unsigned ROW_W  = hrlfd_pkg::ROW_W;
   localparam int unsigned LEN_W  = hrlfd_pkg::LEN_W;
   localparam int unsigned FP_W   = hrlfd_pkg::FP_W;
   localparam int unsigned SHIFT  = hrlfd_pkg::RECIP_SHIFT;
   localparam int unsigned PIX    = FRAME_WIDTH * FRAME_HEIGHT;
   // Rounded-up reciprocal: exact quotient for every position below 2^POS_W.
   localparam int unsigned RECIP   = ((1 << SHIFT) + FRAME_WIDTH - 1) / FRAME_WIDTH;
   localparam int unsigned RECIP_W = $clog2(RECIP + 1);
   localparam int unsigned PROD_W  = POS_W + RECIP_W;
   localparam int unsigned Q_W     = PROD_W - SHIFT;
   localparam logic [CALC_W-1:0]  PIX_C   = CALC_W'(PIX);
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
   localparam logic [COL_W-1:0]   WIDTH_C = COL_W'(FRAME_WIDTH);

   hrlfd_pkg::back_state_type state_ff, state_in;
   logic                div_pend_ff;
   logic [FP_W-1:0]     fp_ff;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   hrlfd_pkg::seg_type  seg2_ff, seg2_in;

   logic [CALC_W-1:0]   fp_ext, fp_eff, len_ext, room, sum, rem_ext;
   logic [LEN_W-1:0]    rem;
   logic                at_end, clip, split;
   hrlfd_pkg::seg_type  seg1;
   logic [Q_W-1:0]      quot;
   logic [Q_W+COL_W-1:0] quot_w;
   logic [POS_W-1:0]    col_full;

   // Place the run against the room left in the frame.
   always_comb begin
      fp_ext  = CALC_W'(fp_ff);
      at_end  = (fp_ext >= PIX_C);
      fp_eff  = at_end ? '0 : fp_ext;
      len_ext = CALC_W'(run.len);
      room    = PIX_C - fp_eff;
      sum     = fp_eff + len_ext;
      rem     = run.len - room[LEN_W-1:0];
      rem_ext = CALC_W'(rem);
      clip    = (rem_ext >= PIX_C);
      split   = 1'b0;

      seg1.pixel_color  = run.color;
      seg1.start_column = at_end ? '0 : col_ff;
      seg1.start_row    = at_end ? '0 : row_ff;
      seg1.run_length   = run.len;
      seg1.end_of_frame = 1'b0;
      seg1.last_segment = 1'b1;
      pos_in            = sum[POS_W-1:0];

      seg2_in.pixel_color  = run.color;
      seg2_in.start_column = '0;
      seg2_in.start_row    = '0;
      seg2_in.run_length   = clip ? PIX_C[LEN_W-1:0] : rem;
      seg2_in.end_of_frame = clip;
      seg2_in.last_segment = 1'b1;

      if (len_ext == room) begin
         seg1.end_of_frame = 1'b1;
         pos_in            = '0;
      end else if (len_ext > room) begin
         // Fill the frame, carry the rest into the next one.
         split             = 1'b1;
         seg1.run_length   = room[LEN_W-1:0];
         seg1.end_of_frame = 1'b1;
         seg1.last_segment = 1'b0;
         pos_in            = clip ? '0 : POS_W'(rem);
      end
      prod_in = PROD_W'(pos_in) * PROD_W'(RECIP_C);
   end

   // Second step of the position split: remainder from the registered quotient.
   always_comb begin
      quot     = prod_ff[PROD_W-1:SHIFT];
      quot_w   = quot * WIDTH_C;
      col_full = pos_ff - POS_W'(quot_w);
      col_in   = col_full[COL_W-1:0];
      row_in   = ROW_W'(quot);
   end

   always_comb begin
      state_in = state_ff;
      run_pop  = 1'b0;
      seg_push = 1'b0;
      seg      = seg1;
      case (state_ff)
         hrlfd_pkg::BK_IDLE: begin
            if (!div_pend_ff && !run_status.empty && !seg_status.full) begin
               run_pop  = 1'b1;
               seg_push = 1'b1;
               if (split) begin
                  state_in = hrlfd_pkg::BK_SECOND;
               end
            end
         end
         hrlfd_pkg::BK_SECOND: begin
            seg = seg2_ff;
            if (!seg_status.full) begin
               seg_push = 1'b1;
               state_in = hrlfd_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = hrlfd_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hrlfd_pkg::BK_IDLE;
         div_pend_ff <= 1'b0;
         fp_ff       <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         div_pend_ff <= run_pop;
         if (run_pop) begin
            fp_ff <= pos_in[FP_W-1:0];
         end
         if (div_pend_ff) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (run_pop) begin
         pos_ff  <= pos_in;
         prod_ff <= prod_in;
         seg2_ff <= seg2_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/hex_run_length_frame_decoder.sv @@
// Hex run-length frame decoder: one ASCII character per word in, run segments
// out. Blanks (space, CR, LF) are dropped; other characters pair into a byte
// whose bit 7 is the color and whose low 7 bits are the run length. The front
// end takes one character every cycle while its two-word run queue has room.
// The back end takes no new run until the column and row of the last are set:
// they come from a reciprocal multiply of the new frame position, registered,
// then a remainder step. A run that crosses the frame end gives its second
// segment from a second state once the result queue has room. Segments wait
// in a two-word result queue; a run's first segment passes the run queue, then
// the result queue. Depends on hrlfd_pkg and the macros.
`default_nettype none

`include "hex_run_length_frame_decoder_macros.svh"

module hex_run_length_frame_decoder #(
   parameter int unsigned FRAME_WIDTH  = hrlfd_pkg::FRAME_WIDTH_DEF,
   parameter int unsigned FRAME_HEIGHT = hrlfd_pkg::FRAME_HEIGHT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output      logic                               req_full,
   input  wire logic [hrlfd_pkg::CHAR_W-1:0]       req_input_char,
   output      logic                               rsp_empty,
   input  wire logic                               rsp_pop,
   output      logic                               rsp_pixel_color,
   output      logic [hrlfd_pkg::COL_W-1:0]        rsp_start_column,
   output      logic [hrlfd_pkg::ROW_W-1:0]        rsp_start_row,
   output      logic [hrlfd_pkg::LEN_W-1:0]        rsp_run_length,
   output      logic                               rsp_end_of_frame,
   output      logic                               rsp_last_segment
);

   localparam int unsigned RUN_W = $bits(hrlfd_pkg::run_type);
   localparam int unsigned SEG_W = $bits(hrlfd_pkg::seg_type);

   logic                    accept;
   logic                    run_push, run_pop, seg_push;
   hrlfd_pkg::run_type      run_in, run_out;
   hrlfd_pkg::seg_type      seg_in, seg_out;
   hrlfd_pkg::q_status_type run_status, seg_status;
   logic [RUN_W-1:0]        run_word;
   logic [SEG_W-1:0]        seg_word;

   assign req_full = run_status.full;
   assign accept   = req_push && !run_status.full;

   hrlfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .char_in  (req_input_char),
      .run_push (run_push),
      .run      (run_in)
   );

   hrlfd_queue #(
      .DEPTH (hrlfd_pkg::QUEUE_DEPTH),
      .WIDTH (RUN_W)
   ) u_run_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (run_push),
      .push_data (run_in),
      .pop       (run_pop),
      .pop_data  (run_word),
      .status    (run_status)
   );

   assign run_out = run_word;

   hrlfd_back #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .run_status (run_status),
      .run        (run_out),
      .run_pop    (run_pop),
      .seg_status (seg_status),
      .seg_push   (seg_push),
      .seg        (seg_in)
   );

   hrlfd_queue #(
      .DEPTH (hrlfd_pkg::QUEUE_DEPTH),
      .WIDTH (SEG_W)
   ) u_seg_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (seg_push),
      .push_data (seg_in),
      .pop       (rsp_pop),
      .pop_data  (seg_word),
      .status    (seg_status)
   );

   assign seg_out          = seg_word;
   assign rsp_empty        = seg_status.empty;
   assign rsp_pixel_color  = seg_out.pixel_color;
   assign rsp_start_column = seg_out.start_column;
   assign rsp_start_row    = seg_out.start_row;
   assign rsp_run_length   = seg_out.run_length;
   assign rsp_end_of_frame = seg_out.end_of_frame;
   assign rsp_last_segment = seg_out.last_segment;

   // The back end never writes into a full result queue.
   `HRLFD_ASSERT_NOW(a_seg_room, clock, reset, seg_push, !seg_status.full)
   // The back end only takes a run that is waiting.
   `HRLFD_ASSERT_NOW(a_run_present, clock, reset, run_pop, !run_status.empty)
   // A segment that is not the last of its run always closes the frame.
   `HRLFD_ASSERT_NOW(a_split_eof, clock, reset, seg_push && !seg_in.last_segment,
                     seg_in.end_of_frame)
   // A taken run blocks the back end from taking another while column and row settle.
   `HRLFD_ASSERT_NEXT(a_run_spacing, clock, reset, run_pop, !run_pop)

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking bench for hex_run_length_frame_decoder: random character
// stream in, run segments out, checked by a scoreboard class against a predictor.
// Depends on hrlfd_pkg and the top-level RTL.
`default_nettype none

module testbench;
   import hrlfd_pkg::*;

   localparam int unsigned FRAME_PIXELS = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF;
   localparam int unsigned TARGET_ITEMS = 1300;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   class segment_scoreboard;
      bit nib_held;
      bit [NIB_W-1:0] nib_hi;
      bit [FP_W-1:0] pos;
      seg_type expected_segs[$];
      int unsigned error_count;

      function new();
         nib_held = 0;
         nib_hi = 0;
         pos = 0;
         error_count = 0;
      endfunction

      // Only digits and uppercase A..F count; everything else reads as zero.
      function bit [NIB_W-1:0] digit_value(bit [CHAR_W-1:0] ch);
         if (ch >= "0" && ch <= "9") return NIB_W'(ch - "0");
         if (ch >= "A" && ch <= "F") return NIB_W'(ch - "A" + 10);
         return 0;
      endfunction

      function int unsigned room();
         if (pos >= FRAME_PIXELS) return FRAME_PIXELS;
         return FRAME_PIXELS - pos;
      endfunction

      function int unsigned pending();
         return expected_segs.size();
      endfunction

      function void add_segment(bit color, int unsigned len, bit eof, bit last);
         seg_type seg;
         seg.pixel_color  = color;
         seg.start_column = COL_W'(pos % FRAME_WIDTH_DEF);
         seg.start_row    = ROW_W'(pos / FRAME_WIDTH_DEF);
         seg.run_length   = LEN_W'(len);
         seg.end_of_frame = eof;
         seg.last_segment = last;
         expected_segs.push_back(seg);
      endfunction

      // Advance the decoder state by one accepted character.
      function void decode_char(bit [CHAR_W-1:0] ch);
         bit [7:0] run_byte;
         int unsigned len, left, rest;
         if (ch == CHAR_SPACE || ch == CHAR_CR || ch == CHAR_LF) return;
         if (!nib_held) begin
            nib_hi = digit_value(ch);
            nib_held = 1;
            return;
         end
         nib_held = 0;
         run_byte = {nib_hi, digit_value(ch)};
         len = 32'(run_byte[6:0]);
         if (len == 0) return;
         if (pos >= FRAME_PIXELS) pos = 0;
         left = FRAME_PIXELS - pos;
         if (len < left) begin
            add_segment(run_byte[7], len, 0, 1);
            pos = FP_W'(pos + len);
         end else if (len == left) begin
            add_segment(run_byte[7], len, 1, 1);
            pos = 0;
         end else begin
            // split at the frame end; the tail restarts at the top left
            add_segment(run_byte[7], left, 1, 0);
            pos = 0;
            rest = len - left;
            if (rest >= FRAME_PIXELS) begin
               add_segment(run_byte[7], FRAME_PIXELS, 1, 1);
            end else begin
               add_segment(run_byte[7], rest, 0, 1);
               pos = FP_W'(rest);
            end
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
         end
      endfunction

      function void match_segment(seg_type got);
         seg_type want;
         if (expected_segs.size() == 0) begin
            $display("%0t: unexpected segment, expected none, got %h", $time, got);
            error_count++;
            return;
         end
         want = expected_segs.pop_front();
         compare_field("pixel_color", 32'(want.pixel_color), 32'(got.pixel_color));
         compare_field("start_column", 32'(want.start_column), 32'(got.start_column));
         compare_field("start_row", 32'(want.start_row), 32'(got.start_row));
         compare_field("run_length", 32'(want.run_length), 32'(got.run_length));
         compare_field("end_of_frame", 32'(want.end_of_frame), 32'(got.end_of_frame));
         compare_field("last_segment", 32'(want.last_segment), 32'(got.last_segment));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   logic [CHAR_W-1:0] req_input_char;
   logic rsp_empty;
   logic rsp_pop;
   logic rsp_pixel_color;
   logic [COL_W-1:0] rsp_start_column;
   logic [ROW_W-1:0] rsp_start_row;
   logic [LEN_W-1:0] rsp_run_length;
   logic rsp_end_of_frame;
   logic rsp_last_segment;

   segment_scoreboard sb;
   int unsigned items_sent;
   int unsigned burst_left;

   bit [CHAR_W-1:0] opening_chars [25] = '{
      CHAR_SPACE, CHAR_CR, CHAR_LF,
      "0", "1", "2", "3", "4", "5", "6", "7",
      "8", "9", "A", "B", "C", "D", "E", "F",
      "8", 8'h00, "a", "7", 8'hFF, "5"
   };

   hex_run_length_frame_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_input_char   (req_input_char),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_start_column (rsp_start_column),
      .rsp_start_row    (rsp_start_row),
      .rsp_run_length   (rsp_run_length),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_last_segment (rsp_last_segment)
   );

   always #1 clock = ~clock;

   function automatic bit [CHAR_W-1:0] hex_char(bit [NIB_W-1:0] v);
      if (v < 10) return "0" + v;
      return CHAR_W'("A" + v - 10);
   endfunction

   function automatic bit [CHAR_W-1:0] blank_char();
      case ($urandom_range(0, 2))
         0: return CHAR_SPACE;
         1: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // Near the frame end, aim at an exact fill or a crossing half the time.
   function automatic bit [LEN_W-1:0] pick_length();
      int unsigned left;
      left = sb.room();
      if (left <= 127 && $urandom_range(0, 1) == 1) begin
         if (left == 127 || $urandom_range(0, 1) == 1) return LEN_W'(left);
         return LEN_W'($urandom_range(left + 1, 127));
      end
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return 127;
         default: return LEN_W'($urandom_range(1, 127));
      endcase
   endfunction

   // Offer one word; returns at the falling edge after it is taken.
   task automatic send_char(input bit [CHAR_W-1:0] ch);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_push <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_push <= 1;
      req_input_char <= ch;
      do @(posedge clock); while (req_full);
      sb.decode_char(ch);
      if (ch != CHAR_SPACE && ch != CHAR_CR && ch != CHAR_LF) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_run(input bit color, input bit [LEN_W-1:0] len);
      bit [7:0] run_byte;
      bit [CHAR_W-1:0] lo_ch;
      run_byte = {color, len};
      lo_ch = hex_char(run_byte[3:0]);
      // lowercase letter: reads as a zero nibble
      if (run_byte[3:0] >= 10 && $urandom_range(0, 24) == 0) lo_ch = lo_ch + 8'h20;
      send_char(hex_char(run_byte[7:4]));
      if ($urandom_range(0, 11) == 0) send_char(blank_char());
      send_char(lo_ch);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.match_segment({rsp_pixel_color, rsp_start_column, rsp_start_row,
                           rsp_run_length, rsp_end_of_frame, rsp_last_segment});
   end

   // Receiver: stall pattern changes every window; one long hold-off early on.
   initial begin
      int unsigned window, mode, tick;
      window = 0;
      tick = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (window == 6) begin
            rsp_pop <= 0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         repeat (64) begin
            case (mode)
               0: rsp_pop <= 1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               2: rsp_pop <= ($urandom_range(0, 3) == 0);
               default: rsp_pop <= (tick % 7) < 3;
            endcase
            tick++;
            @(negedge clock);
         end
         window++;
      end
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int unsigned pick;
      sb = new();
      clock = 0;
      reset = 1;
      req_push = 0;
      req_input_char = 0;
      rsp_pop = 0;
      items_sent = 0;
      burst_left = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (opening_chars[i]) send_char(opening_chars[i]);

      while (items_sent < TARGET_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 2) begin
            send_char(blank_char());
         end else if (pick < 4) begin
            send_char(CHAR_W'($urandom_range(0, 255)));
         end else begin
            // realign to a pair boundary so most runs are well formed
            if (sb.nib_held) send_char(hex_char(NIB_W'($urandom_range(0, 15))));
            send_run(1'($urandom_range(0, 1)), pick_length());
         end
      end
      req_push <= 0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ hex_run_length_frame_decoder.f @@
+incdir+rtl/core
rtl/core/hrlfd_pkg.sv
rtl/core/hrlfd_queue.sv
rtl/core/hrlfd_front.sv
rtl/core/hrlfd_back.sv
rtl/core/hex_run_length_frame_decoder.sv
test/testbench.sv
